FILE: rtl/jpt_pkg.sv
// Shared types and constants for the path tokenizer.
// Result word layout, result kinds, error codes and burst sizing.
// No dependencies.
package jpt_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    typedef enum logic [2:0] {
        KIND_KEY_BYTE = 3'd0,
        KIND_KEY_END  = 3'd1,
        KIND_INDEX    = 3'd2,
        KIND_OK       = 3'd3,
        KIND_ERROR    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NO_ROOT   = 2'd0,
        ERR_UNEXPECT  = 2'd1,
        ERR_EMPTY_KEY = 2'd2,
        ERR_BRACKET   = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  key_byte;
        logic [30:0] index_value;
        err_t        error_code;
        logic [15:0] error_pos;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        result_t [MAX_RESULTS-1:0]       res;
    } burst_t;

endpackage

FILE: rtl/jpt_path_if.sv
// Input channel of the path tokenizer: one path byte per word.
// Depends on nothing.
interface jpt_path_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

FILE: rtl/jpt_token_if.sv
// Output channel of the path tokenizer: one token result per word.
// Depends on nothing.
interface jpt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  key_byte;
    logic [30:0] index_value;
    logic [1:0]  error_code;
    logic [15:0] error_pos;
    logic        run_last;

    modport source (output valid, output kind, output key_byte, output index_value,
                    output error_code, output error_pos, output run_last, input ready);
    modport sink   (input valid, input kind, input key_byte, input index_value,
                    input error_code, input error_pos, input run_last, output ready);
endinterface

FILE: rtl/jpt_step.sv
// Tokenizer state machine: takes one path byte per advance and forms
// the burst of up to three results it causes. Depends on jpt_pkg.
module jpt_step #(
    parameter longint unsigned MAX_PATH_LEN = 65535
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      ch,
    input  logic            last,
    output jpt_pkg::burst_t burst
);

    localparam logic [15:0] POS_CAP =
        (MAX_PATH_LEN > 64'd65535) ? 16'hFFFF : 16'(MAX_PATH_LEN);
    localparam logic [34:0] INDEX_MAX = 35'h07FFF_FFFF;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef enum logic [3:0] {
        M_ROOT,
        M_SEG,
        M_DOTFIRST,
        M_DOTKEY,
        M_BR,
        M_IDX,
        M_QSTR,
        M_QESC,
        M_QCLOSE
    } mode_t;

    mode_t       mode_reg, mode_next, cur;
    logic        qd_reg, qd_next;
    logic [30:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] br_reg, br_next;
    logic        disc_reg, disc_next;

    logic                               is_num;
    logic                               is_key;
    logic [34:0]                        acc_ext;
    logic [34:0]                        acc_mul;
    logic [15:0]                        dot_pos;
    logic [7:0]                         esc_byte;
    logic [7:0]                         close_quote;
    logic [jpt_pkg::CNT_W-1:0]          cnt;
    jpt_pkg::result_t [jpt_pkg::MAX_RESULTS-1:0] res;

    function automatic jpt_pkg::result_t mk_res(
        jpt_pkg::kind_t kind,
        logic [7:0]     kb,
        logic [30:0]    idx,
        jpt_pkg::err_t  code,
        logic [15:0]    epos
    );
        jpt_pkg::result_t r;
        r.kind        = kind;
        r.key_byte    = kb;
        r.index_value = idx;
        r.error_code  = code;
        r.error_pos   = epos;
        r.run_last    = 1'b0;
        return r;
    endfunction

    assign is_num   = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_key   = is_num || ((ch >= 8'h61) && (ch <= 8'h7A)) ||
                      ((ch >= 8'h41) && (ch <= 8'h5A)) || (ch == CH_USCORE);
    assign acc_ext  = {4'd0, acc_reg};
    assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {31'd0, ch[3:0]};
    assign dot_pos  = (pos_reg < POS_CAP) ? pos_reg + 16'd1 : POS_CAP;
    assign close_quote = qd_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        case (ch)
            CH_LOW_N: esc_byte = CH_LF;
            CH_LOW_T: esc_byte = CH_TAB;
            CH_LOW_R: esc_byte = CH_CR;
            default:  esc_byte = ch;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        pos_next  = pos_reg;
        br_next   = br_reg;
        disc_next = disc_reg;
        cur       = mode_reg;
        cnt       = '0;
        res       = '0;

        if (!disc_reg)
        begin
            // a stray byte closes a dot key, then starts a new segment
            if (mode_reg == M_DOTKEY && !is_key)
            begin
                res[cnt] = mk_res(jpt_pkg::KIND_KEY_END, 8'd0, 31'd0,
                                  jpt_pkg::ERR_NO_ROOT, 16'd0);
                cnt = cnt + 1'b1;
                cur = M_SEG;
            end
            mode_next = cur;

            unique case (cur)
                M_ROOT:
                begin
                    if (ch == CH_DOLLAR)
                        mode_next = M_SEG;
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, pos_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                M_SEG:
                begin
                    if (ch == CH_DOT)
                        mode_next = M_DOTFIRST;
                    else if (ch == CH_LBRACK)
                    begin
                        br_next   = pos_reg;
                        mode_next = M_BR;
                    end
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_UNEXPECT, pos_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                M_DOTFIRST:
                begin
                    if (is_key)
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_KEY_BYTE, ch, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                        mode_next = M_DOTKEY;
                    end
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_EMPTY_KEY, pos_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                M_DOTKEY:
                begin
                    res[cnt] = mk_res(jpt_pkg::KIND_KEY_BYTE, ch, 31'd0,
                                      jpt_pkg::ERR_NO_ROOT, 16'd0);
                    cnt = cnt + 1'b1;
                end
                M_BR:
                begin
                    if (is_num)
                    begin
                        acc_next  = {27'd0, ch[3:0]};
                        ovf_next  = 1'b0;
                        mode_next = M_IDX;
                    end
                    else if (ch == CH_SQUOTE || ch == CH_DQUOTE)
                    begin
                        qd_next   = (ch == CH_DQUOTE);
                        mode_next = M_QSTR;
                    end
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_BRACKET, br_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                M_IDX:
                begin
                    if (is_num)
                    begin
                        if (!ovf_reg)
                        begin
                            if (acc_mul > INDEX_MAX)
                                ovf_next = 1'b1;
                            else
                                acc_next = acc_mul[30:0];
                        end
                    end
                    else if (ch == CH_RBRACK && !ovf_reg)
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_INDEX, 8'd0, acc_reg,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                        mode_next = M_SEG;
                    end
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_BRACKET, br_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                M_QSTR:
                begin
                    if (ch == close_quote)
                        mode_next = M_QCLOSE;
                    else if (ch == CH_BSLASH)
                        mode_next = M_QESC;
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_KEY_BYTE, ch, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                    end
                end
                M_QESC:
                begin
                    res[cnt] = mk_res(jpt_pkg::KIND_KEY_BYTE, esc_byte, 31'd0,
                                      jpt_pkg::ERR_NO_ROOT, 16'd0);
                    cnt = cnt + 1'b1;
                    mode_next = M_QSTR;
                end
                M_QCLOSE:
                begin
                    if (ch == CH_RBRACK)
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_KEY_END, 8'd0, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                        mode_next = M_SEG;
                    end
                    else
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_BRACKET, br_reg);
                        cnt = cnt + 1'b1;
                        disc_next = 1'b1;
                    end
                end
                default:
                begin
                    res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                      jpt_pkg::ERR_UNEXPECT, pos_reg);
                    cnt = cnt + 1'b1;
                    disc_next = 1'b1;
                end
            endcase

            // close out the path on its final byte
            if (last && !disc_next)
            begin
                unique case (mode_next)
                    M_SEG:
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_OK, 8'd0, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                    end
                    M_DOTKEY:
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_KEY_END, 8'd0, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                        res[cnt] = mk_res(jpt_pkg::KIND_OK, 8'd0, 31'd0,
                                          jpt_pkg::ERR_NO_ROOT, 16'd0);
                        cnt = cnt + 1'b1;
                    end
                    M_DOTFIRST:
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_EMPTY_KEY, dot_pos);
                        cnt = cnt + 1'b1;
                    end
                    default:
                    begin
                        res[cnt] = mk_res(jpt_pkg::KIND_ERROR, 8'd0, 31'd0,
                                          jpt_pkg::ERR_BRACKET, br_next);
                        cnt = cnt + 1'b1;
                    end
                endcase
            end
        end

        if (last)
        begin
            mode_next = M_ROOT;
            qd_next   = 1'b0;
            acc_next  = '0;
            ovf_next  = 1'b0;
            pos_next  = '0;
            br_next   = '0;
            disc_next = 1'b0;
        end
        else if (pos_reg < POS_CAP)
            pos_next = pos_reg + 16'd1;

        for (int i = 0; i < jpt_pkg::MAX_RESULTS; i++)
            res[i].run_last = (cnt != '0) && (jpt_pkg::CNT_W'(i) == cnt - 1'b1);
    end

    assign burst.count = cnt;
    assign burst.res   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_ROOT;
            qd_reg   <= 1'b0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            br_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            qd_reg   <= qd_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            pos_reg  <= pos_next;
            br_reg   <= br_next;
            disc_reg <= disc_next;
        end
    end

endmodule

FILE: rtl/json_path_tokenizer_unit.sv
// Path tokenizer top level: byte input, token result queue, output word.
// Depends on jpt_pkg, jpt_path_if, jpt_token_if and jpt_step.
// The results of a byte are written into the result queue as the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one result and token
// ready stays high; a byte with up to three results drains one result word per cycle.
// Ready is set by room for three entries in the four-entry result queue.
// Reset: asynchronous; clears the tokenizer state and empties the queue.
module json_path_tokenizer_unit #(
    parameter longint unsigned MAX_PATH_LEN = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    jpt_path_if.sink    path,
    jpt_token_if.source token
);

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    logic                   accept;
    logic                   pop;
    jpt_pkg::burst_t        burst;
    jpt_pkg::result_t       head;
    jpt_pkg::result_t       fifo_mem [RES_DEPTH];
    logic [RES_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [RES_AW:0]        cnt_reg, cnt_next;
    logic [jpt_pkg::CNT_W-1:0] push_cnt;

    assign accept = path.valid && path.ready;
    assign pop    = token.valid && token.ready;

    jpt_step #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .ch      (path.ch),
        .last    (path.last),
        .burst   (burst)
    );

    assign push_cnt    = accept ? burst.count : '0;
    assign cnt_next    = cnt_reg + (RES_AW+1)'(push_cnt) - (RES_AW+1)'(pop);
    assign wr_ptr_next = wr_ptr_reg + RES_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + RES_AW'(pop);

    assign path.ready  = cnt_reg <= (RES_AW+1)'(RES_DEPTH - jpt_pkg::MAX_RESULTS);

    assign head              = fifo_mem[rd_ptr_reg];
    assign token.valid       = cnt_reg != '0;
    assign token.kind        = head.kind;
    assign token.key_byte    = head.key_byte;
    assign token.index_value = head.index_value;
    assign token.error_code  = head.error_code;
    assign token.error_pos   = head.error_pos;
    assign token.run_last    = head.run_last;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jpt_pkg::MAX_RESULTS; i++)
        begin
            if (accept && (jpt_pkg::CNT_W'(i) < burst.count))
                fifo_mem[wr_ptr_reg + RES_AW'(i)] <= burst.res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (RES_AW+1)'(RES_DEPTH))
        else $error("result queue over depth");

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        token.valid && (token.kind == jpt_pkg::KIND_OK || token.kind == jpt_pkg::KIND_ERROR)
        |-> token.run_last)
        else $error("path end result not final in its burst");

    a_ok_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !path.last |->
        burst.res[0].kind != jpt_pkg::KIND_OK && burst.res[1].kind != jpt_pkg::KIND_OK &&
        burst.res[2].kind != jpt_pkg::KIND_OK)
        else $error("path ok reported before final byte");

endmodule

FILE: tb/sv/json_path_tokenizer_unit_tb.sv
// Self-checking testbench for json_path_tokenizer_unit: sends paths byte by byte
// and checks every token word against a built-in tokenizer predictor.
// Depends on jpt_pkg, jpt_path_if, jpt_token_if and the json_path_tokenizer_unit RTL.
module json_path_tokenizer_unit_tb;

    localparam logic [7:0]  CH_DOLLAR  = "$";
    localparam logic [7:0]  CH_DOT     = ".";
    localparam logic [7:0]  CH_OPEN    = "[";
    localparam logic [7:0]  CH_CLOSE   = "]";
    localparam logic [7:0]  CH_SQUOTE  = "'";
    localparam logic [7:0]  CH_DQUOTE  = "\"";
    localparam logic [7:0]  CH_BSLASH  = "\\";
    localparam logic [7:0]  CH_ZERO    = "0";
    localparam logic [7:0]  CH_NINE    = "9";
    localparam logic [7:0]  CH_UNDER   = "_";
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [15:0] POS_CAP    = 16'hFFFF;
    localparam longint unsigned INDEX_MAX = 64'd2147483647;
    localparam int          TOTAL_ITEMS = 330;
    localparam string       KEY_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    typedef enum logic [3:0] {
        W_ROOT,
        W_SEG,
        W_DOT_FIRST,
        W_DOT_KEY,
        W_BRACKET,
        W_INDEX,
        W_QUOTED,
        W_ESCAPE,
        W_QUOTE_CLOSE
    } walk_t;

    class token_scoreboard;
        walk_t       mode;
        bit          quote_dbl;
        logic [30:0] idx_acc;
        bit          idx_ovf;
        logic [15:0] byte_pos;
        logic [15:0] bracket_pos;
        bit          discarding;
        jpt_pkg::result_t expected_tokens[$];
        int          mismatches;
        int          live_bytes;
        int          tokens_checked;
        int          paths_ok;
        int          paths_rejected;

        function new();
            clear_walk();
        endfunction

        function void clear_walk();
            mode        = W_ROOT;
            quote_dbl   = 1'b0;
            idx_acc     = '0;
            idx_ovf     = 1'b0;
            byte_pos    = '0;
            bracket_pos = '0;
            discarding  = 1'b0;
        endfunction

        function bit is_key_char(logic [7:0] c);
            return (c >= CH_ZERO && c <= CH_NINE) || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z") || c == CH_UNDER;
        endfunction

        function void push_token(jpt_pkg::kind_t k, logic [7:0] kb = '0,
                                 logic [30:0] iv = '0,
                                 jpt_pkg::err_t ec = jpt_pkg::ERR_NO_ROOT,
                                 logic [15:0] pos = '0);
            jpt_pkg::result_t r;
            r.kind        = k;
            r.key_byte    = kb;
            r.index_value = iv;
            r.error_code  = ec;
            r.error_pos   = pos;
            r.run_last    = 1'b0;
            expected_tokens = {expected_tokens, r};
        endfunction

        function void flag_error(jpt_pkg::err_t ec, logic [15:0] pos);
            push_token(jpt_pkg::KIND_ERROR, 8'h00, 31'd0, ec, pos);
            discarding = 1'b1;
        endfunction

        function void take_byte(logic [7:0] c, logic lst);
            int              n0;
            logic [15:0]     pos;
            longint unsigned v;
            logic [7:0]      d;
            n0  = expected_tokens.size();
            pos = byte_pos;
            if (!discarding) begin
                live_bytes++;
                if (mode == W_DOT_KEY && !is_key_char(c)) begin
                    push_token(jpt_pkg::KIND_KEY_END);
                    mode = W_SEG;
                end
                case (mode)
                    W_ROOT:
                        if (c == CH_DOLLAR) mode = W_SEG;
                        else flag_error(jpt_pkg::ERR_NO_ROOT, pos);
                    W_SEG:
                        if (c == CH_DOT) begin
                            mode = W_DOT_FIRST;
                        end
                        else if (c == CH_OPEN) begin
                            bracket_pos = pos;
                            mode = W_BRACKET;
                        end
                        else begin
                            flag_error(jpt_pkg::ERR_UNEXPECT, pos);
                        end
                    W_DOT_FIRST:
                        if (is_key_char(c)) begin
                            push_token(jpt_pkg::KIND_KEY_BYTE, c);
                            mode = W_DOT_KEY;
                        end
                        else begin
                            flag_error(jpt_pkg::ERR_EMPTY_KEY, pos);
                        end
                    W_DOT_KEY:
                        push_token(jpt_pkg::KIND_KEY_BYTE, c);
                    W_BRACKET:
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            idx_acc = 31'(c - CH_ZERO);
                            idx_ovf = 1'b0;
                            mode = W_INDEX;
                        end
                        else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                            quote_dbl = (c == CH_DQUOTE);
                            mode = W_QUOTED;
                        end
                        else begin
                            flag_error(jpt_pkg::ERR_BRACKET, bracket_pos);
                        end
                    W_INDEX:
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            if (!idx_ovf) begin
                                v = longint'(idx_acc) * 10 + longint'(c) - longint'(CH_ZERO);
                                if (v > INDEX_MAX) idx_ovf = 1'b1;
                                else idx_acc = v[30:0];
                            end
                        end
                        else if (c == CH_CLOSE && !idx_ovf) begin
                            push_token(jpt_pkg::KIND_INDEX, 8'h00, idx_acc);
                            mode = W_SEG;
                        end
                        else begin
                            flag_error(jpt_pkg::ERR_BRACKET, bracket_pos);
                        end
                    W_QUOTED:
                        if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) mode = W_QUOTE_CLOSE;
                        else if (c == CH_BSLASH) mode = W_ESCAPE;
                        else push_token(jpt_pkg::KIND_KEY_BYTE, c);
                    W_ESCAPE: begin
                        d = c;
                        if (c == "n") d = CH_LF;
                        else if (c == "t") d = CH_TAB;
                        else if (c == "r") d = CH_CR;
                        push_token(jpt_pkg::KIND_KEY_BYTE, d);
                        mode = W_QUOTED;
                    end
                    W_QUOTE_CLOSE:
                        if (c == CH_CLOSE) begin
                            push_token(jpt_pkg::KIND_KEY_END);
                            mode = W_SEG;
                        end
                        else begin
                            flag_error(jpt_pkg::ERR_BRACKET, bracket_pos);
                        end
                    default:
                        flag_error(jpt_pkg::ERR_UNEXPECT, pos);
                endcase

                if (lst && !discarding) begin
                    if (mode == W_SEG) begin
                        push_token(jpt_pkg::KIND_OK);
                    end
                    else if (mode == W_DOT_KEY) begin
                        push_token(jpt_pkg::KIND_KEY_END);
                        push_token(jpt_pkg::KIND_OK);
                    end
                    else if (mode == W_DOT_FIRST) begin
                        flag_error(jpt_pkg::ERR_EMPTY_KEY,
                                   (pos != POS_CAP) ? pos + 16'd1 : POS_CAP);
                    end
                    else begin
                        flag_error(jpt_pkg::ERR_BRACKET, bracket_pos);
                    end
                end
            end

            if (lst) clear_walk();
            else if (byte_pos != POS_CAP) byte_pos++;

            if (expected_tokens.size() > n0)
                expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
        endfunction

        function void compare_field(string name, logic [30:0] want, logic [30:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_token(jpt_pkg::result_t got);
            jpt_pkg::result_t want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                $display("%0t: token with nothing expected, expected none, actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (want.kind == jpt_pkg::KIND_OK) paths_ok++;
            if (want.kind == jpt_pkg::KIND_ERROR) paths_rejected++;
            compare_field("kind", 31'(want.kind), 31'(got.kind));
            compare_field("key_byte", 31'(want.key_byte), 31'(got.key_byte));
            compare_field("index_value", want.index_value, got.index_value);
            compare_field("error_code", 31'(want.error_code), 31'(got.error_code));
            compare_field("error_pos", 31'(want.error_pos), 31'(got.error_pos));
            compare_field("run_last", 31'(want.run_last), 31'(got.run_last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   paths_sent;
    int   items_sent;
    logic [7:0] path_bytes[$];
    token_scoreboard book;

    jpt_path_if  path_bus ();
    jpt_token_if token_bus ();

    json_path_tokenizer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .path  (path_bus),
        .token (token_bus)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic add_byte(logic [7:0] b);
        path_bytes = {path_bytes, b};
    endtask

    task automatic send_byte(logic [7:0] c, logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            path_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        path_bus.valid <= 1'b1;
        path_bus.ch    <= c;
        path_bus.last  <= lst;
        @(posedge clk);
        while (!path_bus.ready) @(posedge clk);
        items_sent++;
        book.take_byte(c, lst);
    endtask

    task automatic send_path();
        idle_on = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < path_bytes.size(); i++)
            send_byte(path_bytes[i], i == path_bytes.size() - 1);
        paths_sent++;
    endtask

    task automatic send_text(string s);
        path_bytes.delete();
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        send_path();
    endtask

    task automatic wait_drained();
        path_bus.valid <= 1'b0;
        @(posedge clk);
        while (book.expected_tokens.size() != 0) @(posedge clk);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic push_index();
        longint unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 99);
            1: v = $urandom_range(0, 32'h7FFF_FFFF);
            2: v = INDEX_MAX - 2 + $urandom_range(0, 4);
            default: v = longint'($urandom()) * $urandom_range(1, 999);
        endcase
        add_byte(CH_OPEN);
        if ($urandom_range(0, 7) == 0) add_byte(CH_ZERO);
        push_text($sformatf("%0d", v));
        add_byte(CH_CLOSE);
    endtask

    task automatic push_quoted();
        logic [7:0] q;
        logic [7:0] b;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        add_byte(CH_OPEN);
        add_byte(q);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) begin
                add_byte(CH_BSLASH);
                case ($urandom_range(0, 5))
                    0: b = "n";
                    1: b = "t";
                    2: b = "r";
                    3: b = q;
                    4: b = CH_BSLASH;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            else begin
                b = 8'($urandom_range(0, 255));
                if (b == q || b == CH_BSLASH) b = "z";
            end
            add_byte(b);
        end
        add_byte(q);
        add_byte(CH_CLOSE);
    endtask

    task automatic build_random_path();
        int pick;
        int k;
        path_bytes.delete();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        add_byte(CH_DOLLAR);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 2))
                0: begin
                    add_byte(CH_DOT);
                    repeat ($urandom_range(1, 6))
                        add_byte(KEY_CHARS[$urandom_range(0, KEY_CHARS.len() - 1)]);
                end
                1: push_index();
                default: push_quoted();
            endcase
        end
        if (pick == 1) begin
            k = $urandom_range(0, path_bytes.size() - 1);
            if ($urandom_range(0, 1)) path_bytes[k] = 8'($urandom_range(0, 255));
            else path_bytes = path_bytes[0:k];
        end
    endtask

    initial begin
        book = new();
        path_bus.valid <= 1'b0;
        path_bus.ch    <= 8'h00;
        path_bus.last  <= 1'b0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("$");
        send_text("x");
        send_text("$x");
        send_text("$.a_Z9[0]['k']");
        send_text("$.ab!");
        send_text("$.a\377");
        send_text("$..x");
        send_text("$.");
        send_text("$.ab$.cd");
        send_text("$[2147483647]");
        send_text("$[2147483648]");
        send_text("$[12a]");
        send_text("$[x]");
        send_text("$[\"a\\nb\\tc\\rd\\\\e\\\"q'\\x\"]");
        send_text("$['a\"b\\'c']");
        send_text("$['ab'x]");
        send_text("$['ab");
        send_text("$['a\\");
        send_text("$[7");
        path_bytes.delete();
        push_text("$['");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        push_text("']");
        send_path();
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            build_random_path();
            send_path();
            if ($urandom_range(0, 39) == 0) wait_drained();
        end

        wait_drained();
        repeat (16) @(posedge clk);
        $display("Covered %0d paths, %0d bytes sent, %0d live bytes, %0d tokens checked",
                 paths_sent, items_sent, book.live_bytes, book.tokens_checked);
        $display("Paths accepted: %0d, paths rejected: %0d, mismatches: %0d",
                 book.paths_ok, book.paths_rejected, book.mismatches);
        if (book.mismatches == 0 && book.expected_tokens.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        jpt_pkg::result_t got;
        int               gap;
        token_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                token_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            token_bus.ready <= 1'b1;
            @(posedge clk);
            while (!token_bus.valid) @(posedge clk);
            got.kind        = jpt_pkg::kind_t'(token_bus.kind);
            got.key_byte    = token_bus.key_byte;
            got.index_value = token_bus.index_value;
            got.error_code  = jpt_pkg::err_t'(token_bus.error_code);
            got.error_pos   = token_bus.error_pos;
            got.run_last    = token_bus.run_last;
            book.check_token(got);
        end
    end

    initial begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/jpt_pkg.sv
rtl/jpt_path_if.sv
rtl/jpt_token_if.sv
rtl/jpt_step.sv
rtl/json_path_tokenizer_unit.sv
tb/sv/json_path_tokenizer_unit_tb.sv
